>>> sv/bvl_pkg.sv
// ============================================================================
// bvl_pkg
// Types and constants shared by the value list engine modules.
// ============================================================================
package bvl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] NIL_IDX = IDX_W'(CAPACITY);

    localparam logic [2:0] ACT_FRONT  = 3'd0;
    localparam logic [2:0] ACT_APPEND = 3'd1;
    localparam logic [2:0] ACT_DELETE = 3'd2;
    localparam logic [2:0] ACT_MODIFY = 3'd3;
    localparam logic [2:0] ACT_INSBEF = 3'd4;
    localparam logic [2:0] ACT_DUMP   = 3'd5;
    localparam logic [2:0] ACT_CLEAR  = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] operand_value;
        logic signed [31:0] match_value;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic               last;
        logic [4:0]         length;
    } result_t;

    // Controller to datapath
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,       // latch request, point walker at head
        CMD_STEP,       // advance walker one node (pv <= cur, cur <= next)
        CMD_FRONT,
        CMD_APPEND,
        CMD_DELETE,
        CMD_MODIFY,
        CMD_INSBEF,
        CMD_CLEAR_STEP, // relink one node of the free chain
        CMD_CLEAR_END
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] action;
        logic       full;
        logic       cur_nil;
        logic       hit;        // node at walker holds key
        logic       next_nil;
        logic       clear_done;
        logic       empty;
    } stat_t;

endpackage

>>> sv/bounded_value_list_engine.sv
// Front insert, append and full or empty results go through load, decode and report; search
// requests also walk the nodes passed over, and clear relinks every node of the free chain.
// A dump strobes one result per cycle, one per node.
// Throughput: one transaction at a time; set by the single-node walker over the store.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (rst_n low, async) empties the list and rebuilds the free chain at once.
// ============================================================================
// bounded_value_list_engine
// Ordered list of signed values in a linked node store with a free chain.
// ============================================================================
module bounded_value_list_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bvl_pkg::request_t request,
    output logic              done,
    output bvl_pkg::result_t  result
);

    bvl_pkg::ctl_t  ctl;
    bvl_pkg::stat_t stat;
    logic signed [31:0] cur_value;
    logic [4:0] length;

    bvl_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .ctl      (ctl),
        .stat     (stat),
        .cur_value(cur_value),
        .length   (length),
        .done     (done),
        .result   (result)
    );

    bvl_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (request),
        .ctl      (ctl),
        .stat     (stat),
        .cur_value(cur_value),
        .length   (length)
    );

endmodule

>>> sv/bvl_ram.sv
// ============================================================================
// bvl_ram
// Generic single-port-write, single-read RAM with registered read data.
// ============================================================================
module bvl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/bvl_datapath.sv
// ============================================================================
// bvl_datapath
// Node store, links, head/tail/free pointers and the list walker.
// ============================================================================
module bvl_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  bvl_pkg::request_t req,
    input  bvl_pkg::ctl_t     ctl,
    output bvl_pkg::stat_t    stat,
    output logic signed [31:0] cur_value,
    output logic [4:0]        length
);

    localparam int IW = bvl_pkg::IDX_W;
    localparam int AW = bvl_pkg::ADDR_W;

    bvl_pkg::request_t req_reg;
    logic [IW-1:0] link_reg [bvl_pkg::CAPACITY];
    logic [IW-1:0] head_reg, tail_reg, free_reg, cur_reg, pv_reg;
    logic [bvl_pkg::CNT_W-1:0] count_reg;
    logic [AW-1:0] clr_reg;

    // value store: walker read address is the node the walker moves to
    logic          v_we;
    logic [AW-1:0] v_waddr, v_raddr;
    logic [31:0]   v_wdata, v_rdata;
    logic [IW-1:0] walk_next;
    logic [IW-1:0] cur_link;
    logic [31:0]   key;

    assign cur_link = (cur_reg < bvl_pkg::NIL_IDX) ? link_reg[cur_reg[AW-1:0]]
                                                   : bvl_pkg::NIL_IDX;

    always_comb
    begin
        case (ctl.cmd)
            bvl_pkg::CMD_LOAD: walk_next = head_reg;
            bvl_pkg::CMD_STEP: walk_next = cur_link;
            default:           walk_next = cur_reg;
        endcase
    end

    assign v_raddr = walk_next[AW-1:0];

    always_comb
    begin
        v_we    = 1'b0;
        v_waddr = free_reg[AW-1:0];
        v_wdata = req_reg.operand_value;
        case (ctl.cmd)
            bvl_pkg::CMD_FRONT, bvl_pkg::CMD_APPEND, bvl_pkg::CMD_INSBEF: v_we = 1'b1;
            bvl_pkg::CMD_MODIFY:
            begin
                v_we    = 1'b1;
                v_waddr = cur_reg[AW-1:0];
            end
            default: v_we = 1'b0;
        endcase
    end

    bvl_ram #(.WIDTH(32), .DEPTH(bvl_pkg::CAPACITY)) u_values (
        .clk  (clk),
        .we   (v_we),
        .waddr(v_waddr),
        .wdata(v_wdata),
        .raddr(v_raddr),
        .rdata(v_rdata)
    );

    assign key = (req_reg.action == bvl_pkg::ACT_DELETE) ? req_reg.operand_value
                                                         : req_reg.match_value;

    assign cur_value       = v_rdata;
    assign length          = 5'(count_reg);
    assign stat.action     = req_reg.action;
    assign stat.full       = (count_reg >= bvl_pkg::CNT_W'(bvl_pkg::CAPACITY));
    assign stat.cur_nil    = (cur_reg >= bvl_pkg::NIL_IDX);
    assign stat.hit        = (v_rdata == key);
    assign stat.next_nil   = (cur_link >= bvl_pkg::NIL_IDX);
    assign stat.clear_done = (clr_reg == AW'(bvl_pkg::CAPACITY - 1));
    assign stat.empty      = (head_reg >= bvl_pkg::NIL_IDX) || (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bvl_pkg::CAPACITY; i++)
            begin
                link_reg[i] <= IW'(i + 1);
            end
            head_reg  <= bvl_pkg::NIL_IDX;
            tail_reg  <= bvl_pkg::NIL_IDX;
            free_reg  <= '0;
            count_reg <= '0;
            cur_reg   <= bvl_pkg::NIL_IDX;
            pv_reg    <= bvl_pkg::NIL_IDX;
            clr_reg   <= '0;
            req_reg   <= '0;
        end
        else
        begin
            case (ctl.cmd)
                bvl_pkg::CMD_LOAD:
                begin
                    req_reg <= req;
                    cur_reg <= head_reg;
                    pv_reg  <= bvl_pkg::NIL_IDX;
                    clr_reg <= '0;
                end
                bvl_pkg::CMD_STEP:
                begin
                    pv_reg  <= cur_reg;
                    cur_reg <= cur_link;
                end
                bvl_pkg::CMD_FRONT:
                begin
                    free_reg  <= link_reg[free_reg[AW-1:0]];
                    link_reg[free_reg[AW-1:0]] <= head_reg;
                    if (head_reg == bvl_pkg::NIL_IDX)
                    begin
                        tail_reg <= free_reg;
                    end
                    head_reg  <= free_reg;
                    count_reg <= count_reg + 1'b1;
                end
                bvl_pkg::CMD_APPEND:
                begin
                    free_reg <= link_reg[free_reg[AW-1:0]];
                    link_reg[free_reg[AW-1:0]] <= bvl_pkg::NIL_IDX;
                    if (tail_reg < bvl_pkg::NIL_IDX)
                    begin
                        link_reg[tail_reg[AW-1:0]] <= free_reg;
                    end
                    else
                    begin
                        head_reg <= free_reg;
                    end
                    tail_reg  <= free_reg;
                    count_reg <= count_reg + 1'b1;
                end
                bvl_pkg::CMD_INSBEF:
                begin
                    free_reg <= link_reg[free_reg[AW-1:0]];
                    link_reg[free_reg[AW-1:0]] <= cur_reg;
                    if (pv_reg < bvl_pkg::NIL_IDX)
                    begin
                        link_reg[pv_reg[AW-1:0]] <= free_reg;
                    end
                    else
                    begin
                        head_reg <= free_reg;
                    end
                    count_reg <= count_reg + 1'b1;
                end
                bvl_pkg::CMD_DELETE:
                begin
                    if (pv_reg < bvl_pkg::NIL_IDX)
                    begin
                        link_reg[pv_reg[AW-1:0]] <= cur_link;
                    end
                    else
                    begin
                        head_reg <= cur_link;
                    end
                    if (tail_reg == cur_reg)
                    begin
                        tail_reg <= pv_reg;
                    end
                    link_reg[cur_reg[AW-1:0]] <= free_reg;
                    free_reg  <= cur_reg;
                    count_reg <= count_reg - 1'b1;
                end
                bvl_pkg::CMD_CLEAR_STEP:
                begin
                    link_reg[clr_reg] <= IW'(clr_reg) + 1'b1;
                    clr_reg <= clr_reg + 1'b1;
                end
                bvl_pkg::CMD_CLEAR_END:
                begin
                    link_reg[clr_reg] <= IW'(clr_reg) + 1'b1;
                    head_reg  <= bvl_pkg::NIL_IDX;
                    tail_reg  <= bvl_pkg::NIL_IDX;
                    free_reg  <= '0;
                    count_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bvl_pkg::CNT_W'(bvl_pkg::CAPACITY))
        else $error("element count above capacity");
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == bvl_pkg::NIL_IDX))
        else $error("empty list with a head node");
    a_delete_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.cmd == bvl_pkg::CMD_DELETE) |-> (cur_reg < bvl_pkg::NIL_IDX))
        else $error("delete without a node");
`endif

endmodule

>>> sv/bvl_controller.sv
// ============================================================================
// bvl_controller
// Sequencer for requests: search walk, update and result strobes.
// ============================================================================
module bvl_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output bvl_pkg::ctl_t     ctl,
    input  bvl_pkg::stat_t    stat,
    input  logic signed [31:0] cur_value,
    input  logic [4:0]        length,
    output logic              done,
    output bvl_pkg::result_t  result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_DUMP,
        S_CLEAR,
        S_REPORT
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       done_reg, done_next;
    bvl_pkg::result_t result_reg, result_next;
    bvl_pkg::cmd_t cmd;

    assign busy   = (state_reg != S_IDLE);
    assign ctl.cmd = cmd;
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        cmd         = bvl_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = bvl_pkg::CMD_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                status_next = bvl_pkg::ST_OK;
                state_next  = S_REPORT;
                case (stat.action)
                    bvl_pkg::ACT_FRONT:
                    begin
                        if (stat.full) status_next = bvl_pkg::ST_FULL;
                        else cmd = bvl_pkg::CMD_FRONT;
                    end
                    bvl_pkg::ACT_APPEND:
                    begin
                        if (stat.full) status_next = bvl_pkg::ST_FULL;
                        else cmd = bvl_pkg::CMD_APPEND;
                    end
                    bvl_pkg::ACT_INSBEF:
                    begin
                        if (stat.full) status_next = bvl_pkg::ST_FULL;
                        else state_next = S_SEARCH;
                    end
                    bvl_pkg::ACT_DELETE, bvl_pkg::ACT_MODIFY: state_next = S_SEARCH;
                    bvl_pkg::ACT_DUMP:
                    begin
                        if (stat.empty) status_next = bvl_pkg::ST_EMPTY;
                        else state_next = S_DUMP;
                    end
                    bvl_pkg::ACT_CLEAR: state_next = S_CLEAR;
                    default: state_next = S_REPORT;
                endcase
            end
            S_SEARCH:
            begin
                // value of the node at the walker is valid here
                if (stat.cur_nil)
                begin
                    status_next = bvl_pkg::ST_NOTFOUND;
                    state_next  = S_REPORT;
                end
                else if (stat.hit)
                begin
                    state_next = S_REPORT;
                    case (stat.action)
                        bvl_pkg::ACT_DELETE: cmd = bvl_pkg::CMD_DELETE;
                        bvl_pkg::ACT_MODIFY: cmd = bvl_pkg::CMD_MODIFY;
                        default:             cmd = bvl_pkg::CMD_INSBEF;
                    endcase
                end
                else
                begin
                    cmd = bvl_pkg::CMD_STEP;
                end
            end
            S_DUMP:
            begin
                done_next           = 1'b1;
                result_next.status  = bvl_pkg::ST_OK;
                result_next.element = cur_value;
                result_next.last    = stat.next_nil;
                result_next.length  = length;
                if (stat.next_nil) state_next = S_IDLE;
                else cmd = bvl_pkg::CMD_STEP;
            end
            S_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    cmd        = bvl_pkg::CMD_CLEAR_END;
                    state_next = S_REPORT;
                end
                else
                begin
                    cmd = bvl_pkg::CMD_CLEAR_STEP;
                end
            end
            S_REPORT:
            begin
                done_next           = 1'b1;
                result_next.status  = status_reg;
                result_next.element = '0;
                result_next.last    = 1'b1;
                result_next.length  = length;
                state_next          = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= bvl_pkg::ST_OK;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

`ifndef SYNTH
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.last) |-> (state_reg == S_IDLE))
        else $error("final result while still busy");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cmd == bvl_pkg::CMD_NONE || cmd == bvl_pkg::CMD_LOAD))
        else $error("datapath command while idle");
    a_report_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPORT) |=> done_reg)
        else $error("report without strobe");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the value list engine: a directed stimulus table,
// then random request sequences, each result checked against a list model.
// ============================================================================
module tb_top;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    bvl_pkg::request_t request;
    logic              done;
    bvl_pkg::result_t  result;

    bounded_value_list_engine u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // List model: the values in order, as a plain queue
    logic signed [31:0] list_vals[$];
    bvl_pkg::result_t   expected_results[$];
    int                 mismatch_count;
    int                 error_count;

    task automatic predict_request(input bvl_pkg::request_t rq);
        int               pos;
        bvl_pkg::result_t r;
        pos = -1;
        r = '0;
        r.last = 1'b1;
        for (int i = 0; i < list_vals.size(); i++)
        begin
            if (pos < 0 && ((rq.action == bvl_pkg::ACT_DELETE &&
                             list_vals[i] == rq.operand_value) ||
                ((rq.action == bvl_pkg::ACT_MODIFY || rq.action == bvl_pkg::ACT_INSBEF) &&
                 list_vals[i] == rq.match_value)))
                pos = i;
        end
        case (rq.action)
            bvl_pkg::ACT_FRONT, bvl_pkg::ACT_APPEND:
            begin
                if (list_vals.size() >= bvl_pkg::CAPACITY) r.status = bvl_pkg::ST_FULL;
                else if (rq.action == bvl_pkg::ACT_FRONT) list_vals.push_front(rq.operand_value);
                else list_vals.push_back(rq.operand_value);
            end
            bvl_pkg::ACT_DELETE:
            begin
                if (pos < 0) r.status = bvl_pkg::ST_NOTFOUND;
                else list_vals.delete(pos);
            end
            bvl_pkg::ACT_MODIFY:
            begin
                if (pos < 0) r.status = bvl_pkg::ST_NOTFOUND;
                else list_vals[pos] = rq.operand_value;
            end
            bvl_pkg::ACT_INSBEF:
            begin
                if (list_vals.size() >= bvl_pkg::CAPACITY) r.status = bvl_pkg::ST_FULL;
                else if (pos < 0) r.status = bvl_pkg::ST_NOTFOUND;
                else list_vals.insert(pos, rq.operand_value);
            end
            bvl_pkg::ACT_DUMP:
            begin
                if (list_vals.size() == 0) r.status = bvl_pkg::ST_EMPTY;
            end
            bvl_pkg::ACT_CLEAR: list_vals.delete();
            default: ;
        endcase
        r.length = 5'(list_vals.size());
        if (rq.action == bvl_pkg::ACT_DUMP && list_vals.size() != 0)
        begin
            for (int i = 0; i < list_vals.size(); i++)
            begin
                r.element = list_vals[i];
                r.last = (i == list_vals.size() - 1);
                expected_results.push_back(r);
            end
        end
        else
            expected_results.push_back(r);
    endtask

    // Check every strobed result at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (mismatch_count++ < 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                bvl_pkg::result_t e;
                e = expected_results.pop_front();
                if (result !== e)
                begin
                    error_count++;
                    if (mismatch_count++ < 10)
                        $display("mismatch: expected %p actual %p", e, result);
                end
            end
        end
    end

    task automatic send_request(input bvl_pkg::request_t rq);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        // the previous transaction released start on the last falling edge
        repeat (gap + 1) @(negedge clk);
        request <= rq;
        start   <= 1'b1;
        do @(posedge clk); while (busy);
        predict_request(rq);
        @(negedge clk);
        start <= 1'b0;
    endtask

    function automatic bvl_pkg::request_t make_req(input logic [2:0] a,
                                                   input logic signed [31:0] o,
                                                   input logic signed [31:0] m);
        bvl_pkg::request_t rq;
        rq.action = a;
        rq.operand_value = o;
        rq.match_value = m;
        return rq;
    endfunction

    // Directed table; rows with a typed result are checked against it too
    typedef struct {
        bvl_pkg::request_t rq;
        logic              has_exp;
        bvl_pkg::result_t  exp;
    } row_t;

    row_t stim_table[$];

    initial
    begin
        bvl_pkg::request_t rq;
        logic signed [31:0] pick;
        int sent;
        start = 1'b0;
        request = '0;
        rst_n = 1'b0;
        mismatch_count = 0;
        error_count = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        stim_table = '{
            '{make_req(bvl_pkg::ACT_DUMP, 0, 0), 1, '{bvl_pkg::ST_EMPTY, 0, 1, 0}},
            '{make_req(bvl_pkg::ACT_DELETE, 5, 0), 1, '{bvl_pkg::ST_NOTFOUND, 0, 1, 0}},
            '{make_req(bvl_pkg::ACT_MODIFY, 5, 5), 1, '{bvl_pkg::ST_NOTFOUND, 0, 1, 0}},
            '{make_req(bvl_pkg::ACT_INSBEF, 5, 5), 1, '{bvl_pkg::ST_NOTFOUND, 0, 1, 0}},
            '{make_req(bvl_pkg::ACT_FRONT, 32'sh7fffffff, 0), 1,
              '{bvl_pkg::ST_OK, 0, 1, 1}},
            '{make_req(bvl_pkg::ACT_MODIFY, 32'sh80000000, 32'sh7fffffff), 1,
              '{bvl_pkg::ST_OK, 0, 1, 1}},
            '{make_req(bvl_pkg::ACT_INSBEF, -1, 32'sh80000000), 1,
              '{bvl_pkg::ST_OK, 0, 1, 2}},
            '{make_req(bvl_pkg::ACT_APPEND, 0, -1), 1, '{bvl_pkg::ST_OK, 0, 1, 3}},
            '{make_req(bvl_pkg::ACT_DUMP, 0, 0), 0, '0},
            '{make_req(bvl_pkg::ACT_DELETE, 0, 0), 0, '0},
            '{make_req(bvl_pkg::ACT_DELETE, -1, 0), 0, '0},
            '{make_req(3'd7, -1, -1), 0, '0},
            '{make_req(bvl_pkg::ACT_DUMP, 0, 0), 0, '0},
            '{make_req(bvl_pkg::ACT_CLEAR, -1, -1), 1, '{bvl_pkg::ST_OK, 0, 1, 0}},
            '{make_req(bvl_pkg::ACT_APPEND, 42, 0), 0, '0},
            '{make_req(bvl_pkg::ACT_DELETE, 42, 0), 1, '{bvl_pkg::ST_OK, 0, 1, 0}},
            '{make_req(bvl_pkg::ACT_DUMP, 0, 0), 1, '{bvl_pkg::ST_EMPTY, 0, 1, 0}}
        };
        foreach (stim_table[i])
        begin
            send_request(stim_table[i].rq);
            // the row's own result is the newest one queued
            if (stim_table[i].has_exp &&
                expected_results[expected_results.size() - 1] !== stim_table[i].exp)
            begin
                error_count++;
                if (mismatch_count++ < 10)
                    $display("table row %0d: model disagrees with typed result", i);
            end
        end
        // fill to capacity, then hit the full case on all inserting actions
        for (int i = 0; i < bvl_pkg::CAPACITY; i++)
            send_request(make_req(bvl_pkg::ACT_APPEND, $urandom, 0));
        send_request(make_req(bvl_pkg::ACT_FRONT, 1, 0));
        send_request(make_req(bvl_pkg::ACT_APPEND, 1, 0));
        send_request(make_req(bvl_pkg::ACT_INSBEF, 1, list_vals[0]));
        send_request(make_req(bvl_pkg::ACT_DUMP, 0, 0));

        // pause until everything drains
        while (expected_results.size() != 0) @(negedge clk);

        sent = 0;
        while (sent < 320)
        begin
            rq.action = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 9) < 4)
                rq.action = $urandom_range(0, 1) ? bvl_pkg::ACT_APPEND : bvl_pkg::ACT_INSBEF;
            if (rq.action == bvl_pkg::ACT_CLEAR && $urandom_range(0, 3) != 0)
                rq.action = bvl_pkg::ACT_DUMP;
            // small value pool so keys hit often; sometimes full random
            pick = $urandom_range(0, 3) == 0 ? $signed($urandom) : $urandom_range(0, 7) - 4;
            if (list_vals.size() != 0 && $urandom_range(0, 2) != 0)
                pick = list_vals[$urandom_range(0, list_vals.size() - 1)];
            rq.operand_value = $urandom_range(0, 1) ? $signed($urandom) : pick;
            rq.match_value = pick;
            if (rq.action == bvl_pkg::ACT_DELETE) rq.operand_value = pick;
            send_request(rq);
            sent++;
            if (sent == 160)
                while (expected_results.size() != 0) @(negedge clk);
        end

        while (expected_results.size() != 0) @(negedge clk);
        repeat (bvl_pkg::CAPACITY + 8) @(negedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("bounded_value_list_engine regression: pass");
        else
            $display("bounded_value_list_engine regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("bounded_value_list_engine regression: fail");
        $finish;
    end
endmodule

>>> filelist.f
sv/bvl_pkg.sv
sv/bvl_ram.sv
sv/bvl_datapath.sv
sv/bvl_controller.sv
sv/bounded_value_list_engine.sv
tb/tb_top.sv
